@@ design/pssn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pssn_pkg: shared types and constants of the PPPoE server session table
// Table depth, protocol codes, handshake phases, reply kinds and the
// command and cell-control structs that run between the modules.
// ----------------------------------------------------------------------------
package pssn_pkg;

  localparam int MAX_CLIENTS = 16;
  localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CNT_W = $clog2(MAX_CLIENTS + 1);

  localparam int IN_W      = 138;
  localparam int IN_DATA_W = 144;
  localparam int OUT_W     = 72;

  localparam logic [15:0] ETH_DISC   = 16'h8863;
  localparam logic [15:0] ETH_SESS   = 16'h8864;
  localparam logic [7:0]  CODE_PADI  = 8'h09;
  localparam logic [7:0]  CODE_PADR  = 8'h19;
  localparam logic [7:0]  CODE_PADT  = 8'ha7;
  localparam logic [7:0]  CODE_SESS  = 8'h00;
  localparam logic [15:0] PROTO_LCP  = 16'hc021;
  localparam logic [15:0] PROTO_IPCP = 16'h8021;

  localparam logic [7:0] CP_CONF_REQ = 8'd1;
  localparam logic [7:0] CP_CONF_ACK = 8'd2;
  localparam logic [7:0] CP_TERM_REQ = 8'd5;
  localparam logic [7:0] CP_TERM_ACK = 8'd6;

  localparam logic [3:0] PH_OFFERED   = 4'd0;
  localparam logic [3:0] PH_ASSIGNED  = 4'd1;
  localparam logic [3:0] PH_LCP_REQ   = 4'd2;
  localparam logic [3:0] PH_LCP_OPEN  = 4'd3;
  localparam logic [3:0] PH_IPCP_REQ  = 4'd4;
  localparam logic [3:0] PH_IPCP_OPEN = 4'd6;
  localparam logic [3:0] PH_IPCP_TERM = 4'd7;
  localparam logic [3:0] PH_IPCP_DOWN = 4'd8;
  localparam logic [3:0] PH_LCP_TERM  = 4'd9;
  localparam logic [3:0] PH_LCP_DOWN  = 4'd10;

  localparam logic [3:0] RK_PADO          = 4'd0;
  localparam logic [3:0] RK_PADS          = 4'd1;
  localparam logic [3:0] RK_LCP_ACK       = 4'd2;
  localparam logic [3:0] RK_IPCP_ACK      = 4'd4;
  localparam logic [3:0] RK_LCP_TERM_ACK  = 4'd6;
  localparam logic [3:0] RK_IPCP_TERM_ACK = 4'd8;
  localparam logic [3:0] RK_TABLE_FULL    = 4'd10;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_APPEND,
    OP_UPDATE,
    OP_REMOVE
  } pssn_op_e;

  typedef struct packed {
    logic [47:0] mac;
    logic [15:0] session;
    logic [3:0]  phase;
  } pssn_entry_t;

  // table command issued in the decide cycle
  typedef struct packed {
    pssn_op_e          op;
    logic [IDX_W-1:0]  idx;
    logic              set_sess;
    pssn_entry_t       data;
  } pssn_cmd_t;

  typedef struct packed {
    logic load;
    logic update;
    logic set_sess;
    logic shift;
  } pssn_cell_ctl_t;

endpackage
`default_nettype wire

@@ design/pssn_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pssn_cell: one client slot of the session table
// Holds MAC, session and phase, compares MAC and session against the search keys,
// and takes its right neighbor's entry when the table compacts.
// ----------------------------------------------------------------------------
module pssn_cell (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire pssn_pkg::pssn_cell_ctl_t ctl_i,
  input  wire pssn_pkg::pssn_entry_t    wr_i,
  input  wire pssn_pkg::pssn_entry_t    nbr_i,
  input  wire                           valid_i,
  input  wire  [47:0]                   key_mac_i,
  input  wire  [15:0]                   key_sess_i,
  output pssn_pkg::pssn_entry_t         entry_o,
  output logic                          mac_hit_o,
  output logic                          sess_hit_o
);
  import pssn_pkg::*;

  pssn_entry_t entry_q, entry_d;
  logic        mac_hit_q, sess_hit_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.load) begin
      entry_d = wr_i;
    end else if (ctl_i.shift) begin
      entry_d = nbr_i;
    end else if (ctl_i.update) begin
      entry_d.phase = wr_i.phase;
      if (ctl_i.set_sess) begin
        entry_d.session = wr_i.session;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_hit_q  <= 1'b0;
      sess_hit_q <= 1'b0;
    end else begin
      mac_hit_q  <= valid_i && (entry_q.mac == key_mac_i);
      sess_hit_q <= valid_i && (entry_q.session == key_sess_i);
    end
  end

  assign entry_o    = entry_q;
  assign mac_hit_o  = mac_hit_q;
  assign sess_hit_o = sess_hit_q;

endmodule
`default_nettype wire

@@ design/pssn_chain.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pssn_chain: row of client cells
// Decodes the table command into per-slot controls, wires each slot to
// its right neighbor for compaction and gathers the search hits.
// ----------------------------------------------------------------------------
module pssn_chain (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire pssn_pkg::pssn_cmd_t              cmd_i,
  input  wire  [pssn_pkg::CNT_W-1:0]            count_i,
  input  wire  [47:0]                           key_mac_i,
  input  wire  [15:0]                           key_sess_i,
  output logic [pssn_pkg::MAX_CLIENTS-1:0]      mac_hit_o,
  output logic [pssn_pkg::MAX_CLIENTS-1:0]      sess_hit_o,
  output logic [pssn_pkg::MAX_CLIENTS-1:0][3:0] phase_o
);
  import pssn_pkg::*;

  pssn_entry_t entry [MAX_CLIENTS];

  for (genvar i = 0; i < MAX_CLIENTS; i++) begin : g_cell
    pssn_cell_ctl_t ctl;
    pssn_entry_t    nbr;

    always_comb begin
      ctl.load     = (cmd_i.op == OP_APPEND) && (cmd_i.idx == IDX_W'(i));
      ctl.update   = (cmd_i.op == OP_UPDATE) && (cmd_i.idx == IDX_W'(i));
      ctl.set_sess = cmd_i.set_sess;
      ctl.shift    = (cmd_i.op == OP_REMOVE) && (IDX_W'(i) >= cmd_i.idx);
    end

    if (i == MAX_CLIENTS - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entry[i+1];
    end

    pssn_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .wr_i       (cmd_i.data),
      .nbr_i      (nbr),
      .valid_i    (CNT_W'(i) < count_i),
      .key_mac_i  (key_mac_i),
      .key_sess_i (key_sess_i),
      .entry_o    (entry[i]),
      .mac_hit_o  (mac_hit_o[i]),
      .sess_hit_o (sess_hit_o[i])
    );

    assign phase_o[i] = entry[i].phase;
  end

endmodule
`default_nettype wire

@@ design/pppoe_server_session_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pppoe_server_session_table_unit: PPPoE access concentrator client table
// Takes one parsed frame per item and answers the discovery and LCP/IPCP
// handshakes from an ordered table of clients.
// ----------------------------------------------------------------------------
// Each frame passes through capture, search in every slot, and decide and
// update, then sends one reply per output handshake; a frame that calls for
// no reply frees the input after the decide step, a frame with two replies
// after the second reply is taken. The search runs in parallel across the
// row of slot cells, and removal compacts the row in one shift of every slot
// from the removed one on toward the head. One frame is in flight at a time.
module pppoe_server_session_table_unit (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // dest_ok, ether_type, pppoe_code, frame_session, ppp_proto, cp_code,
  // cp_ident, source_mac, name_match, fresh_session, zero pad
  input  wire  [pssn_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  wire                           m_axis_tready_i,
  // reply_mac, reply_session, reply_ident
  output logic [pssn_pkg::OUT_W-1:0]    m_axis_tdata_o,
  // reply_kind
  output logic [3:0]                    m_axis_tuser_o,
  // last_reply
  output logic                          m_axis_tlast_o
);
  import pssn_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IN_W-1:0]  in_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       ident_q, ident_d;

  logic [3:0]  kind_q;
  logic [47:0] rmac_q;
  logic [15:0] rsess_q;
  logic [7:0]  rident_q;
  logic        pair_q, sel_q;

  logic [MAX_CLIENTS-1:0]      mac_hit, sess_hit;
  logic [MAX_CLIENTS-1:0][3:0] phase;

  pssn_cmd_t cmd;

  logic        f_dest_ok, f_name_match;
  logic [15:0] f_ether, f_fsess, f_proto, f_fresh;
  logic [7:0]  f_code, f_cpc, f_cpi;
  logic [47:0] f_mac;

  assign f_dest_ok    = in_q[0];
  assign f_ether      = in_q[16:1];
  assign f_code       = in_q[24:17];
  assign f_fsess      = in_q[40:25];
  assign f_proto      = in_q[56:41];
  assign f_cpc        = in_q[64:57];
  assign f_cpi        = in_q[72:65];
  assign f_mac        = in_q[120:73];
  assign f_name_match = in_q[121];
  assign f_fresh      = in_q[137:122];

  pssn_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .count_i    (count_q),
    .key_mac_i  (f_mac),
    .key_sess_i (f_fsess),
    .mac_hit_o  (mac_hit),
    .sess_hit_o (sess_hit),
    .phase_o    (phase)
  );

  // first matching slot wins
  logic [IDX_W-1:0] mac_idx, sess_idx;
  always_comb begin
    mac_idx  = '0;
    sess_idx = '0;
    for (int i = MAX_CLIENTS - 1; i >= 0; i--) begin
      if (mac_hit[i]) begin
        mac_idx = IDX_W'(i);
      end
      if (sess_hit[i]) begin
        sess_idx = IDX_W'(i);
      end
    end
  end

  logic [3:0]  ph_mac, ph_sess, next_ph, rep_kind;
  logic [1:0]  n_rep;
  logic [15:0] rep_sess;
  logic [7:0]  rep_ident;
  logic        advance;

  assign ph_mac  = phase[mac_idx];
  assign ph_sess = phase[sess_idx];

  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NONE;
    n_rep     = 2'd0;
    rep_kind  = RK_PADO;
    rep_sess  = 16'h0000;
    rep_ident = 8'h00;
    ident_d   = ident_q;
    next_ph   = ph_sess;
    advance   = 1'b0;

    if (state_q == ST_DECIDE && f_dest_ok) begin
      if (f_ether == ETH_DISC) begin
        case (f_code)
          CODE_PADI: begin
            n_rep = 2'd1;
            if (count_q >= CNT_W'(MAX_CLIENTS)) begin
              rep_kind = RK_TABLE_FULL;
            end else begin
              cmd.op       = OP_APPEND;
              cmd.idx      = count_q[IDX_W-1:0];
              cmd.data.mac = f_mac;
              rep_kind     = RK_PADO;
            end
          end
          CODE_PADR: begin
            if (f_name_match && (|mac_hit) && ph_mac == PH_OFFERED) begin
              cmd.op           = OP_UPDATE;
              cmd.idx          = mac_idx;
              cmd.set_sess     = 1'b1;
              cmd.data.session = f_fresh;
              cmd.data.phase   = PH_ASSIGNED;
              n_rep            = 2'd1;
              rep_kind         = RK_PADS;
              rep_sess         = f_fresh;
            end
          end
          CODE_PADT: begin
            if ((|mac_hit) && ph_mac == PH_LCP_DOWN) begin
              cmd.op  = OP_REMOVE;
              cmd.idx = mac_idx;
            end
          end
          default: ;
        endcase
      end else if (f_ether == ETH_SESS && f_code == CODE_SESS && (|sess_hit)) begin
        if (f_proto == PROTO_LCP) begin
          case (f_cpc)
            CP_CONF_REQ: if (ph_sess == PH_ASSIGNED) begin
              next_ph  = PH_LCP_REQ;
              advance  = 1'b1;
              ident_d  = f_cpi;
              n_rep    = 2'd2;
              rep_kind = RK_LCP_ACK;
            end
            CP_CONF_ACK: if (ph_sess == PH_LCP_REQ) begin
              next_ph = PH_LCP_OPEN;
              advance = 1'b1;
            end
            CP_TERM_REQ: if (ph_sess == PH_IPCP_DOWN) begin
              next_ph  = PH_LCP_TERM;
              advance  = 1'b1;
              n_rep    = 2'd2;
              rep_kind = RK_LCP_TERM_ACK;
            end
            CP_TERM_ACK: if (ph_sess == PH_LCP_TERM) begin
              next_ph = PH_LCP_DOWN;
              advance = 1'b1;
            end
            default: ;
          endcase
        end else if (f_proto == PROTO_IPCP) begin
          case (f_cpc)
            CP_CONF_REQ: if (ph_sess == PH_LCP_OPEN) begin
              next_ph  = PH_IPCP_REQ;
              advance  = 1'b1;
              n_rep    = 2'd2;
              rep_kind = RK_IPCP_ACK;
            end
            CP_CONF_ACK: if (ph_sess == PH_IPCP_REQ) begin
              next_ph = PH_IPCP_OPEN;
              advance = 1'b1;
            end
            CP_TERM_REQ: if (ph_sess == PH_IPCP_OPEN) begin
              next_ph  = PH_IPCP_TERM;
              advance  = 1'b1;
              n_rep    = 2'd2;
              rep_kind = RK_IPCP_TERM_ACK;
            end
            CP_TERM_ACK: if (ph_sess == PH_IPCP_TERM) begin
              next_ph = PH_IPCP_DOWN;
              advance = 1'b1;
            end
            default: ;
          endcase
        end
        if (advance) begin
          cmd.op         = OP_UPDATE;
          cmd.idx        = sess_idx;
          cmd.data.phase = next_ph;
        end
        rep_sess  = f_fsess;
        rep_ident = ident_d;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.op == OP_APPEND) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (cmd.op == OP_REMOVE) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_axis_tvalid_i) state_d = ST_MATCH;
      ST_MATCH:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = (n_rep != 2'd0) ? ST_OUT : ST_IDLE;
      ST_OUT:    if (m_axis_tready_i && (!pair_q || sel_q)) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ident_q <= 8'h00;
      pair_q  <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ident_q <= ident_d;
      if (state_q == ST_DECIDE) begin
        pair_q <= (n_rep == 2'd2);
        sel_q  <= 1'b0;
      end else if (state_q == ST_OUT && m_axis_tready_i) begin
        // advance to the second reply of a pair
        sel_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid_i) begin
      in_q <= s_axis_tdata_i[IN_W-1:0];
    end
    if (state_q == ST_DECIDE) begin
      kind_q   <= rep_kind;
      rmac_q   <= f_mac;
      rsess_q  <= rep_sess;
      rident_q <= rep_ident;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = {rident_q, rsess_q, rmac_q};
  assign m_axis_tuser_o  = sel_q ? 4'(kind_q + 4'd1) : kind_q;
  assign m_axis_tlast_o  = !pair_q || sel_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_CLIENTS))
    else $error("client count above table depth");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input open while a reply is pending");

  a_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_APPEND) |=> (count_q == CNT_W'($past(count_q) + 1'b1)))
    else $error("append did not grow the table");

  a_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_REMOVE) |=> (count_q == CNT_W'($past(count_q) - 1'b1)))
    else $error("remove did not shrink the table");

  a_full_no_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CNT_W'(MAX_CLIENTS)) |-> (cmd.op != OP_APPEND))
    else $error("append into a full table");

endmodule
`default_nettype wire

@@ test/pppoe_server_session_table_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pppoe_server_session_table_unit_tb: self-checking bench for the session table
// Drives parsed frames into the stream input and keeps a shadow client table
// that predicts every reply. Each reply is checked field by field against the
// oldest prediction. Traffic runs from directed edge cases and a full table
// to long random handshakes, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module pppoe_server_session_table_unit_tb;
  import pssn_pkg::*;

  // reply kinds that the package does not name
  localparam logic [3:0] RK_LCP_REQ       = 4'd3;
  localparam logic [3:0] RK_IPCP_REQ      = 4'd5;
  localparam logic [3:0] RK_LCP_TERM_REQ  = 4'd7;
  localparam logic [3:0] RK_IPCP_TERM_REQ = 4'd9;

  localparam int RANDOM_FRAMES = 640;

  typedef struct {
    logic        dest_ok;
    logic [15:0] ether_type;
    logic [7:0]  pppoe_code;
    logic [15:0] frame_session;
    logic [15:0] ppp_proto;
    logic [7:0]  cp_code;
    logic [7:0]  cp_ident;
    logic [47:0] source_mac;
    logic        name_match;
    logic [15:0] fresh_session;
  } frame_t;

  typedef struct {
    logic [3:0]  kind;
    logic [47:0] mac;
    logic [15:0] session;
    logic [7:0]  ident;
    logic        last;
  } reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tready = 1'b0;
  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [OUT_W-1:0]     m_axis_tdata_o;
  logic [3:0]           m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  // shadow client table
  logic [47:0] client_mac [MAX_CLIENTS];
  logic [15:0] client_session [MAX_CLIENTS];
  logic [3:0]  client_phase [MAX_CLIENTS];
  int          client_count = 0;
  logic [7:0]  last_ident = '0;

  reply_t pending_replies[$];

  int fail_count = 0;
  int frames_sent = 0;
  int replies_seen = 0;
  int full_answers = 0;
  int removals = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_run = 0;

  pppoe_server_session_table_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int slot_of_mac(logic [47:0] mac);
    for (int i = 0; i < client_count; i++) begin
      if (client_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  function automatic int slot_of_session(logic [15:0] sess);
    for (int i = 0; i < client_count; i++) begin
      if (client_session[i] == sess) return i;
    end
    return -1;
  endfunction

  task automatic add_reply(logic [3:0] kind, logic [47:0] mac, logic [15:0] sess,
                           logic [7:0] ident, logic last);
    reply_t r;
    r.kind = kind;
    r.mac = mac;
    r.session = sess;
    r.ident = ident;
    r.last = last;
    pending_replies.push_back(r);
  endtask

  task automatic session_pair(logic [3:0] first_kind, logic [3:0] second_kind,
                              logic [47:0] mac, logic [15:0] sess);
    add_reply(first_kind, mac, sess, last_ident, 1'b0);
    add_reply(second_kind, mac, sess, last_ident, 1'b1);
  endtask

  // advance the shadow table by one accepted frame and queue its replies
  task automatic answer_frame(frame_t f);
    int idx;
    if (!f.dest_ok) return;
    if (f.ether_type == ETH_DISC) begin
      if (f.pppoe_code == CODE_PADI) begin
        if (client_count >= MAX_CLIENTS) begin
          add_reply(RK_TABLE_FULL, f.source_mac, '0, '0, 1'b1);
          full_answers++;
        end else begin
          client_mac[client_count] = f.source_mac;
          client_session[client_count] = '0;
          client_phase[client_count] = PH_OFFERED;
          client_count++;
          add_reply(RK_PADO, f.source_mac, '0, '0, 1'b1);
        end
      end else if (f.pppoe_code == CODE_PADR) begin
        if (!f.name_match) return;
        idx = slot_of_mac(f.source_mac);
        if (idx < 0 || client_phase[idx] != PH_OFFERED) return;
        client_session[idx] = f.fresh_session;
        client_phase[idx] = PH_ASSIGNED;
        add_reply(RK_PADS, f.source_mac, f.fresh_session, '0, 1'b1);
      end else if (f.pppoe_code == CODE_PADT) begin
        idx = slot_of_mac(f.source_mac);
        if (idx < 0 || client_phase[idx] != PH_LCP_DOWN) return;
        // compact toward the head
        for (int i = idx; i + 1 < client_count; i++) begin
          client_mac[i] = client_mac[i + 1];
          client_session[i] = client_session[i + 1];
          client_phase[i] = client_phase[i + 1];
        end
        client_mac[client_count - 1] = '0;
        client_session[client_count - 1] = '0;
        client_phase[client_count - 1] = PH_OFFERED;
        client_count--;
        removals++;
      end
      return;
    end
    if (f.ether_type != ETH_SESS || f.pppoe_code != CODE_SESS) return;
    if (f.ppp_proto != PROTO_LCP && f.ppp_proto != PROTO_IPCP) return;
    idx = slot_of_session(f.frame_session);
    if (idx < 0) return;
    if (f.ppp_proto == PROTO_LCP) begin
      if (f.cp_code == CP_CONF_REQ && client_phase[idx] == PH_ASSIGNED) begin
        client_phase[idx] = PH_LCP_REQ;
        last_ident = f.cp_ident;
        session_pair(RK_LCP_ACK, RK_LCP_REQ, f.source_mac, client_session[idx]);
      end else if (f.cp_code == CP_CONF_ACK && client_phase[idx] == PH_LCP_REQ) begin
        client_phase[idx] = PH_LCP_OPEN;
      end else if (f.cp_code == CP_TERM_REQ && client_phase[idx] == PH_IPCP_DOWN) begin
        client_phase[idx] = PH_LCP_TERM;
        session_pair(RK_LCP_TERM_ACK, RK_LCP_TERM_REQ, f.source_mac, client_session[idx]);
      end else if (f.cp_code == CP_TERM_ACK && client_phase[idx] == PH_LCP_TERM) begin
        client_phase[idx] = PH_LCP_DOWN;
      end
    end else begin
      if (f.cp_code == CP_CONF_REQ && client_phase[idx] == PH_LCP_OPEN) begin
        client_phase[idx] = PH_IPCP_REQ;
        session_pair(RK_IPCP_ACK, RK_IPCP_REQ, f.source_mac, client_session[idx]);
      end else if (f.cp_code == CP_CONF_ACK && client_phase[idx] == PH_IPCP_REQ) begin
        client_phase[idx] = PH_IPCP_OPEN;
      end else if (f.cp_code == CP_TERM_REQ && client_phase[idx] == PH_IPCP_OPEN) begin
        client_phase[idx] = PH_IPCP_TERM;
        session_pair(RK_IPCP_TERM_ACK, RK_IPCP_TERM_REQ, f.source_mac,
                     client_session[idx]);
      end else if (f.cp_code == CP_TERM_ACK && client_phase[idx] == PH_IPCP_TERM) begin
        client_phase[idx] = PH_IPCP_DOWN;
      end
    end
  endtask

  // ---------------------------------------------------------------- frame builders

  function automatic logic [47:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic frame_t noise_frame();
    frame_t f;
    f.dest_ok = 1'($urandom_range(0, 1));
    f.ether_type = 16'($urandom);
    f.pppoe_code = 8'($urandom);
    f.frame_session = 16'($urandom);
    f.ppp_proto = 16'($urandom);
    f.cp_code = 8'($urandom);
    f.cp_ident = 8'($urandom);
    f.source_mac = random_mac();
    f.name_match = 1'($urandom_range(0, 1));
    f.fresh_session = 16'($urandom);
    return f;
  endfunction

  function automatic frame_t disc_frame(logic [7:0] code, logic [47:0] mac, logic name_ok,
                                        logic [15:0] fresh);
    frame_t f;
    f = noise_frame();
    f.dest_ok = 1'b1;
    f.ether_type = ETH_DISC;
    f.pppoe_code = code;
    f.source_mac = mac;
    f.name_match = name_ok;
    f.fresh_session = fresh;
    return f;
  endfunction

  function automatic frame_t sess_frame(logic [15:0] proto, logic [7:0] code,
                                        logic [15:0] sess, logic [7:0] ident);
    frame_t f;
    f = noise_frame();
    f.dest_ok = 1'b1;
    f.ether_type = ETH_SESS;
    f.pppoe_code = CODE_SESS;
    f.ppp_proto = proto;
    f.cp_code = code;
    f.frame_session = sess;
    f.cp_ident = ident;
    return f;
  endfunction

  // ---------------------------------------------------------------- input side

  // call at a falling edge; returns at a falling edge
  task automatic send_frame(frame_t f);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {{(IN_DATA_W - IN_W){1'b0}}, f.fresh_session, f.name_match,
                    f.source_mac, f.cp_ident, f.cp_code, f.ppp_proto, f.frame_session,
                    f.pppoe_code, f.ether_type, f.dest_ok};
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    answer_frame(f);
    frames_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    // hold off between bursts
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 10);
    end
  endtask

  // ---------------------------------------------------------------- output side

  always @(negedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run = $urandom_range(10, 60);
    end
    stall_run--;
    case (stall_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = 1'($urandom_range(0, 1));
      2: m_axis_tready = ($urandom_range(0, 5) != 0);
      default: m_axis_tready = (stall_run % 8 == 0);
    endcase
  end

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : reply_monitor
    reply_t got;
    reply_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      got.kind = m_axis_tuser_o;
      got.mac = m_axis_tdata_o[47:0];
      got.session = m_axis_tdata_o[63:48];
      got.ident = m_axis_tdata_o[71:64];
      got.last = m_axis_tlast_o;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        note_failure($sformatf("unexpected reply kind=%0d mac=%h sess=%h ident=%h last=%b",
                               got.kind, got.mac, got.session, got.ident, got.last));
      end else begin
        want = pending_replies.pop_front();
        if (got.kind !== want.kind || got.mac !== want.mac || got.session !== want.session ||
            got.ident !== want.ident || got.last !== want.last) begin
          note_failure($sformatf({"reply mismatch: expected kind=%0d mac=%h sess=%h ",
                                  "ident=%h last=%b, got kind=%0d mac=%h sess=%h ",
                                  "ident=%h last=%b"},
                                 want.kind, want.mac, want.session, want.ident, want.last,
                                 got.kind, got.mac, got.session, got.ident, got.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_discovery_edges();
    frame_t f;
    send_frame(disc_frame(CODE_PADI, 48'hffff_ffff_ffff, 1'b0, 16'h0000));
    send_frame(disc_frame(CODE_PADI, 48'h0, 1'b1, 16'hffff));
    // no name match: drop
    send_frame(disc_frame(CODE_PADR, 48'hffff_ffff_ffff, 1'b0, 16'h1111));
    send_frame(disc_frame(CODE_PADR, 48'hffff_ffff_ffff, 1'b1, 16'hffff));
    send_frame(disc_frame(CODE_PADR, 48'h0, 1'b1, 16'h0000));
    // already assigned: drop
    send_frame(disc_frame(CODE_PADR, 48'hffff_ffff_ffff, 1'b1, 16'h2222));
    f = disc_frame(CODE_PADI, random_mac(), 1'b1, 16'h0);
    f.dest_ok = 1'b0;
    send_frame(f);
    f = disc_frame(CODE_PADI, random_mac(), 1'b1, 16'h0);
    f.ether_type = 16'h0800;
    send_frame(f);
    send_frame(disc_frame(8'hff, random_mac(), 1'b1, 16'h0));
    // terminate before the final phase: drop
    send_frame(disc_frame(CODE_PADT, 48'hffff_ffff_ffff, 1'b1, 16'h0));
  endtask

  task automatic test_session_handshake();
    frame_t f;
    send_frame(sess_frame(PROTO_LCP, CP_CONF_REQ, 16'hffff, 8'hff));
    send_frame(sess_frame(PROTO_LCP, CP_CONF_ACK, 16'hffff, 8'h00));
    send_frame(sess_frame(PROTO_LCP, CP_CONF_ACK, 16'hffff, 8'h00));
    send_frame(sess_frame(PROTO_IPCP, CP_CONF_REQ, 16'hffff, 8'h00));
    send_frame(sess_frame(PROTO_IPCP, CP_CONF_ACK, 16'hffff, 8'h55));
    send_frame(sess_frame(PROTO_IPCP, CP_TERM_REQ, 16'hffff, 8'haa));
    send_frame(sess_frame(PROTO_IPCP, CP_TERM_ACK, 16'hffff, 8'h01));
    send_frame(sess_frame(PROTO_LCP, CP_TERM_REQ, 16'hffff, 8'h02));
    send_frame(sess_frame(PROTO_LCP, CP_TERM_ACK, 16'hffff, 8'h03));
    f = sess_frame(PROTO_LCP, CP_CONF_REQ, 16'h0000, 8'h10);
    f.pppoe_code = 8'h01;
    send_frame(f);
    send_frame(sess_frame(16'h0021, CP_CONF_REQ, 16'h0000, 8'h11));
    send_frame(sess_frame(PROTO_LCP, CP_CONF_REQ, 16'h1234, 8'h12));
    // remove the head client, the other one moves up
    send_frame(disc_frame(CODE_PADT, 48'hffff_ffff_ffff, 1'b0, 16'h0));
    send_frame(sess_frame(PROTO_LCP, CP_CONF_REQ, 16'h0000, 8'h00));
  endtask

  task automatic test_table_full();
    send_frame(disc_frame(CODE_PADI, 48'h0, 1'b1, 16'h0));
    while (client_count < MAX_CLIENTS) begin
      send_frame(disc_frame(CODE_PADI, random_mac(), 1'b1, 16'h0));
    end
    send_frame(disc_frame(CODE_PADI, random_mac(), 1'b1, 16'h0));
    send_frame(disc_frame(CODE_PADI, 48'hffff_ffff_ffff, 1'b0, 16'hffff));
  endtask

  // mostly the next legal step of a random client, with noise mixed in
  task automatic pick_frame(output frame_t f, output bit ignored);
    int r;
    int idx;
    logic [15:0] fresh;
    r = $urandom_range(0, 99);
    f = noise_frame();
    ignored = 1'b0;
    if (r < 8) begin
      ignored = 1'b1;
    end else if (r < 12 && client_count > 0) begin
      idx = $urandom_range(0, client_count - 1);
      f = sess_frame(($urandom_range(0, 1) != 0) ? PROTO_LCP : PROTO_IPCP,
                     ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 6)) : 8'($urandom),
                     client_session[idx], 8'($urandom));
      ignored = 1'b1;
    end else if (r < 14 && client_count > 0) begin
      f = disc_frame(CODE_PADR, client_mac[$urandom_range(0, client_count - 1)], 1'b0,
                     16'($urandom));
      ignored = 1'b1;
    end else if (r < 16) begin
      f = sess_frame(PROTO_LCP, CP_CONF_REQ, 16'($urandom), 8'($urandom));
      f.dest_ok = 1'b0;
      ignored = 1'b1;
    end else if (client_count == 0 ||
                 (r < 30 && (client_count < MAX_CLIENTS || r < 17))) begin
      if (client_count > 0 && $urandom_range(0, 19) == 0)
        f = disc_frame(CODE_PADI, client_mac[$urandom_range(0, client_count - 1)], 1'b1, '0);
      else
        f = disc_frame(CODE_PADI, random_mac(), 1'($urandom_range(0, 1)), 16'($urandom));
    end else begin
      idx = $urandom_range(0, client_count - 1);
      case (client_phase[idx])
        PH_OFFERED: begin
          fresh = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
          f = disc_frame(CODE_PADR, client_mac[idx], 1'b1, fresh);
        end
        PH_ASSIGNED:
          f = sess_frame(PROTO_LCP, CP_CONF_REQ, client_session[idx], 8'($urandom));
        PH_LCP_REQ:
          f = sess_frame(PROTO_LCP, CP_CONF_ACK, client_session[idx], 8'($urandom));
        PH_LCP_OPEN:
          f = sess_frame(PROTO_IPCP, CP_CONF_REQ, client_session[idx], 8'($urandom));
        PH_IPCP_REQ:
          f = sess_frame(PROTO_IPCP, CP_CONF_ACK, client_session[idx], 8'($urandom));
        PH_IPCP_OPEN:
          f = sess_frame(PROTO_IPCP, CP_TERM_REQ, client_session[idx], 8'($urandom));
        PH_IPCP_TERM:
          f = sess_frame(PROTO_IPCP, CP_TERM_ACK, client_session[idx], 8'($urandom));
        PH_IPCP_DOWN:
          f = sess_frame(PROTO_LCP, CP_TERM_REQ, client_session[idx], 8'($urandom));
        PH_LCP_TERM:
          f = sess_frame(PROTO_LCP, CP_TERM_ACK, client_session[idx], 8'($urandom));
        default:
          f = disc_frame(CODE_PADT, client_mac[idx], 1'($urandom_range(0, 1)),
                         16'($urandom));
      endcase
    end
  endtask

  task automatic test_random_traffic();
    frame_t f;
    bit ignored;
    int useful;
    useful = 0;
    while (useful < RANDOM_FRAMES) begin
      pick_frame(f, ignored);
      send_frame(f);
      if (!ignored) useful++;
    end
  endtask

  // ---------------------------------------------------------------- run

  initial begin
    int drain_cycles;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_discovery_edges();
    test_session_handshake();
    test_table_full();
    test_random_traffic();

    drain_cycles = 0;
    while (pending_replies.size() > 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (pending_replies.size() > 0)
      note_failure($sformatf("%0d replies never arrived", pending_replies.size()));
    repeat (20) @(posedge clk_i);

    $display("Sent %0d frames and checked %0d replies through full client handshakes,",
             frames_sent, replies_seen);
    $display("  with %0d table-full answers and %0d clients removed; %0d failures",
             full_answers, removals, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
